### hdl/btcl_pkg.sv
package btcl_pkg;

	// default iteration count of the angle unit
	localparam int unsigned CORDIC_STEPS_DEFAULT = 24;

	// vertex queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QAW = $clog2(QDEPTH);

	// register indexes of the configuration port
	localparam logic [1:0] REG_MIN_LENGTH = 2'd0;
	localparam logic [1:0] REG_DEGEN_LIMIT = 2'd1;

	// fixed point constants
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [32:0] DEG_PER_RAD_Q24 = 33'sd961263669;
	localparam logic [23:0] DEG180_Q16 = 24'd11796480;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// one vertex as it waits in the queue
	typedef struct packed {
		logic signed [31:0] ix;
		logic signed [31:0] iy;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic bypass;
		logic clear;
	} item_t;

	// back end sequencer
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ISQ0, ST_ISQ1, ST_ISQ2, ST_IRT,
		ST_OSQ0, ST_OSQ1, ST_OSQ2, ST_ORT,
		ST_DVS, ST_DVW,
		ST_DOT0, ST_DOT1, ST_DOT2,
		ST_CSQ0, ST_CSQ1, ST_CSW,
		ST_CRI, ST_CRS,
		ST_DEG0, ST_DEG1,
		ST_DL0, ST_DL1, ST_DL2, ST_DLW,
		ST_SC0, ST_SC1, ST_SC2, ST_SC3, ST_SC4,
		ST_FIN
	} back_state_t;

	// arctangent of 2^-i, radians Q2.30
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'h3243F6A8;
			5'd1: v = 30'h1DAC6705;
			5'd2: v = 30'h0FADBAFC;
			5'd3: v = 30'h07F56EA6;
			5'd4: v = 30'h03FEAB76;
			5'd5: v = 30'h01FFD55B;
			5'd6: v = 30'h00FFFAAA;
			5'd7: v = 30'h007FFF55;
			5'd8: v = 30'h003FFFEA;
			5'd9: v = 30'h001FFFFD;
			5'd10: v = 30'h000FFFFF;
			5'd11: v = 30'h0007FFFF;
			5'd12: v = 30'h0003FFFF;
			5'd13: v = 30'h0001FFFF;
			5'd14: v = 30'h0000FFFF;
			5'd15: v = 30'h00007FFF;
			5'd16: v = 30'h00003FFF;
			5'd17: v = 30'h00001FFF;
			5'd18: v = 30'h00000FFF;
			5'd19: v = 30'h000007FF;
			5'd20: v = 30'h000003FF;
			5'd21: v = 30'h000001FF;
			5'd22: v = 30'h000000FF;
			5'd23: v = 30'h0000007F;
			5'd24: v = 30'h0000003F;
			5'd25: v = 30'h0000001F;
			5'd26: v = 30'h0000000F;
			5'd27: v = 30'h00000008;
			5'd28: v = 30'h00000004;
			5'd29: v = 30'h00000002;
			5'd30: v = 30'h00000001;
			default: v = 30'h00000000;
		endcase
		return v;
	endfunction

endpackage

### hdl/btcl_front.sv
module btcl_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [31:0] in_tan_x,
	input logic signed [31:0] in_tan_y,
	input logic signed [31:0] out_tan_x,
	input logic signed [31:0] out_tan_y,
	input logic bypass,
	input logic clear_stats,
	output btcl_pkg::item_t q_item,
	output logic q_valid,
	input logic q_pop
);

	btcl_pkg::item_t fifo_q [btcl_pkg::QDEPTH];
	logic [btcl_pkg::QAW-1:0] wr_q, rd_q;
	logic [btcl_pkg::QAW:0] cnt_q;
	logic push;

	// accept while the queue has room
	assign in_stall = (cnt_q == (btcl_pkg::QAW+1)'(btcl_pkg::QDEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign q_item = fifo_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{ix: in_tan_x, iy: in_tan_y, ox: out_tan_x, oy: out_tan_y,
				bypass: bypass, clear: clear_stats};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			case ({push, q_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/btcl_isqrt.sv
module btcl_isqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] rad,
	output logic busy,
	output logic done,
	output logic [31:0] root
);

	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0] cnt_q;
	logic busy_q, done_q;
	logic [35:0] rem_sh, trial;
	logic ge;

	// one result bit per cycle
	assign rem_sh = {rem_q, rad_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge = (rem_sh >= trial);

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= rad;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			rem_q <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### hdl/btcl_div.sv
module btcl_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [32:0] num,
	input logic [31:0] den,
	output logic busy,
	output logic done,
	output logic signed [31:0] quo
);

	// quotient of num * 2^30 / den toward zero, with |num| <= den

	logic [31:0] den_q, rem_q;
	logic [30:0] sh_q, q_q;
	logic neg_q;
	logic [4:0] cnt_q;
	logic busy_q, done_q;
	logic [32:0] num_mag, r2;
	logic ge;

	assign num_mag = num[32] ? 33'(-num) : num;
	assign r2 = {rem_q, sh_q[30]};
	assign ge = (r2 >= {1'b0, den_q});

	assign busy = busy_q;
	assign done = done_q;
	assign quo = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

	// restoring long division, one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= num_mag[32:1];
			sh_q <= {num_mag[0], 30'd0};
			q_q <= '0;
			neg_q <= num[32];
		end else if (busy_q) begin
			rem_q <= ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
			sh_q <= {sh_q[29:0], 1'b0};
			q_q <= {q_q[29:0], ge};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd30) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### hdl/btcl_back.sv
module btcl_back #(
	parameter int unsigned CORDIC_STEPS = btcl_pkg::CORDIC_STEPS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input btcl_pkg::item_t q_item,
	input logic q_valid,
	output logic q_pop,
	input logic [15:0] min_length,
	input logic [10:0] degenerate_limit,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] new_in_x,
	output logic signed [31:0] new_in_y,
	output logic signed [31:0] new_out_x,
	output logic signed [31:0] new_out_y,
	output logic locked,
	output logic [23:0] deviation,
	output logic [15:0] running_pairs,
	output logic [23:0] running_max_dev
);

	btcl_pkg::back_state_t state_q, state_d;

	// working registers
	logic signed [31:0] ix_q, iy_q, ox_q, oy_q;
	logic [31:0] il_q, ol_q, s_q;
	logic signed [31:0] uix_q, uiy_q, uox_q, uoy_q, nx_q, ny_q, c_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic signed [65:0] acc_q, prod_q;
	logic [4:0] step_q;
	logic [2:0] dsel_q;
	logic signed [31:0] nix_q, niy_q, nox_q, noy_q;
	logic locked_q;
	logic [23:0] dev_q;
	logic [15:0] pairs_q;
	logic [23:0] maxdev_q;

	// output register
	logic ovalid_q;
	logic signed [31:0] o_nix_q, o_niy_q, o_nox_q, o_noy_q;
	logic o_locked_q;
	logic [23:0] o_dev_q, o_maxdev_q;
	logic [15:0] o_pairs_q;

	// shared units
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic sq_start, sq_busy, sq_done;
	logic [63:0] sq_rad;
	logic [31:0] sq_root;
	logic dv_start, dv_busy, dv_done;
	logic signed [32:0] dv_num;
	logic [31:0] dv_den;
	logic signed [31:0] dv_quo;
	logic fin_go;

	btcl_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .rad(sq_rad),
		.busy(sq_busy), .done(sq_done), .root(sq_root)
	);

	btcl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num), .den(dv_den),
		.busy(dv_busy), .done(dv_done), .quo(dv_quo)
	);

	assign mul_p = 66'(mul_a) * 66'(mul_b);

	// divider operand select
	always_comb begin
		case (dsel_q)
			3'd0: dv_num = 33'(ix_q);
			3'd1: dv_num = 33'(iy_q);
			3'd2: dv_num = 33'(ox_q);
			3'd3: dv_num = 33'(oy_q);
			3'd4: dv_num = dx_q;
			default: dv_num = dy_q;
		endcase
		if (dsel_q < 3'd2) dv_den = il_q;
		else if (dsel_q < 3'd4) dv_den = ol_q;
		else dv_den = sq_root;
	end

	// cosine from the dot product, truncated toward zero and clamped
	logic signed [65:0] sum_w;
	logic [65:0] sum_mag;
	logic [30:0] cmag;
	logic signed [31:0] c_w;
	assign sum_w = acc_q + prod_q;
	assign sum_mag = sum_w[65] ? 66'(-sum_w) : sum_w;
	assign cmag = (sum_mag[65:30] > 36'(btcl_pkg::ONE_Q30)) ? btcl_pkg::ONE_Q30 :
		sum_mag[60:30];
	assign c_w = sum_w[65] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});

	// rounded rescale of a product by 2^-30, saturated
	logic [65:0] smag;
	logic [65:0] sround;
	logic [35:0] sr;
	logic signed [31:0] scale_w;
	assign smag = prod_q[65] ? 66'(-prod_q) : prod_q;
	assign sround = smag + 66'h2000_0000;
	assign sr = sround[65:30];
	always_comb begin
		if (prod_q[65]) begin
			scale_w = (sr >= 36'h0_8000_0000) ? 32'sh8000_0000 : -$signed(sr[31:0]);
		end else begin
			scale_w = (sr >= 36'h0_8000_0000) ? 32'sh7FFF_FFFF : $signed(sr[31:0]);
		end
	end

	// one cordic vectoring step
	logic signed [33:0] xs, ys, atan_w, zc;
	assign xs = cx_q >>> step_q;
	assign ys = cy_q >>> step_q;
	assign atan_w = $signed({4'b0000, btcl_pkg::atan_q30(step_q)});
	always_comb begin
		if (cz_q < 34'sd0) zc = '0;
		else if (cz_q > btcl_pkg::PI_Q30) zc = btcl_pkg::PI_Q30;
		else zc = cz_q;
	end

	// radians to degrees, deviation from straight
	logic signed [65:0] deg_sum;
	logic [24:0] deg_w;
	logic [23:0] deg_c;
	assign deg_sum = prod_q + 66'sh20_0000_0000;
	assign deg_w = deg_sum[62:38];
	assign deg_c = (deg_w > {1'b0, btcl_pkg::DEG180_Q16}) ? btcl_pkg::DEG180_Q16 : deg_w[23:0];

	// running statistics after this vertex
	logic [15:0] pairs_n;
	logic [23:0] maxdev_n;
	assign pairs_n = (locked_q && pairs_q != 16'hFFFF) ? pairs_q + 1'b1 : pairs_q;
	assign maxdev_n = (locked_q && dev_q > maxdev_q) ? dev_q : maxdev_q;

	assign fin_go = (state_q == btcl_pkg::ST_FIN) && (!ovalid_q || !out_stall);

	// sequencer next state and unit controls
	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		mul_a = '0;
		mul_b = '0;
		sq_start = 1'b0;
		dv_start = 1'b0;
		sq_rad = sum_w[63:0];
		case (state_q)
			btcl_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					state_d = q_item.bypass ? btcl_pkg::ST_FIN : btcl_pkg::ST_ISQ0;
				end
			end
			btcl_pkg::ST_ISQ0: begin
				mul_a = 33'(ix_q);
				mul_b = 33'(ix_q);
				state_d = btcl_pkg::ST_ISQ1;
			end
			btcl_pkg::ST_ISQ1: begin
				mul_a = 33'(iy_q);
				mul_b = 33'(iy_q);
				state_d = btcl_pkg::ST_ISQ2;
			end
			btcl_pkg::ST_ISQ2: begin
				sq_start = 1'b1;
				state_d = btcl_pkg::ST_IRT;
			end
			btcl_pkg::ST_IRT: begin
				if (sq_done) state_d = btcl_pkg::ST_OSQ0;
			end
			btcl_pkg::ST_OSQ0: begin
				mul_a = 33'(ox_q);
				mul_b = 33'(ox_q);
				state_d = btcl_pkg::ST_OSQ1;
			end
			btcl_pkg::ST_OSQ1: begin
				mul_a = 33'(oy_q);
				mul_b = 33'(oy_q);
				state_d = btcl_pkg::ST_OSQ2;
			end
			btcl_pkg::ST_OSQ2: begin
				sq_start = 1'b1;
				state_d = btcl_pkg::ST_ORT;
			end
			btcl_pkg::ST_ORT: begin
				if (sq_done) begin
					if (il_q > {16'd0, min_length} && sq_root > {16'd0, min_length})
						state_d = btcl_pkg::ST_DVS;
					else
						state_d = btcl_pkg::ST_FIN;
				end
			end
			btcl_pkg::ST_DVS: begin
				dv_start = 1'b1;
				state_d = btcl_pkg::ST_DVW;
			end
			btcl_pkg::ST_DVW: begin
				if (dv_done) begin
					if (dsel_q == 3'd3) state_d = btcl_pkg::ST_DOT0;
					else if (dsel_q == 3'd5) state_d = btcl_pkg::ST_SC0;
					else state_d = btcl_pkg::ST_DVS;
				end
			end
			btcl_pkg::ST_DOT0: begin
				mul_a = 33'(uix_q);
				mul_b = 33'(uox_q);
				state_d = btcl_pkg::ST_DOT1;
			end
			btcl_pkg::ST_DOT1: begin
				mul_a = 33'(uiy_q);
				mul_b = 33'(uoy_q);
				state_d = btcl_pkg::ST_DOT2;
			end
			btcl_pkg::ST_DOT2: state_d = btcl_pkg::ST_CSQ0;
			btcl_pkg::ST_CSQ0: begin
				mul_a = 33'(c_q);
				mul_b = 33'(c_q);
				state_d = btcl_pkg::ST_CSQ1;
			end
			btcl_pkg::ST_CSQ1: begin
				sq_rad = 64'h1000_0000_0000_0000 - prod_q[63:0];
				sq_start = 1'b1;
				state_d = btcl_pkg::ST_CSW;
			end
			btcl_pkg::ST_CSW: begin
				if (sq_done) state_d = btcl_pkg::ST_CRI;
			end
			btcl_pkg::ST_CRI: state_d = btcl_pkg::ST_CRS;
			btcl_pkg::ST_CRS: begin
				if (step_q == 5'(CORDIC_STEPS - 1)) state_d = btcl_pkg::ST_DEG0;
			end
			btcl_pkg::ST_DEG0: begin
				mul_a = zc[32:0];
				mul_b = btcl_pkg::DEG_PER_RAD_Q24;
				state_d = btcl_pkg::ST_DEG1;
			end
			btcl_pkg::ST_DEG1: state_d = btcl_pkg::ST_DL0;
			btcl_pkg::ST_DL0: begin
				mul_a = dx_q;
				mul_b = dx_q;
				state_d = btcl_pkg::ST_DL1;
			end
			btcl_pkg::ST_DL1: begin
				mul_a = dy_q;
				mul_b = dy_q;
				state_d = btcl_pkg::ST_DL2;
			end
			btcl_pkg::ST_DL2: begin
				sq_start = 1'b1;
				state_d = btcl_pkg::ST_DLW;
			end
			btcl_pkg::ST_DLW: begin
				if (sq_done) begin
					if (sq_root <= {21'd0, degenerate_limit}) state_d = btcl_pkg::ST_SC0;
					else state_d = btcl_pkg::ST_DVS;
				end
			end
			btcl_pkg::ST_SC0: begin
				mul_a = -33'(nx_q);
				mul_b = $signed({1'b0, il_q});
				state_d = btcl_pkg::ST_SC1;
			end
			btcl_pkg::ST_SC1: begin
				mul_a = -33'(ny_q);
				mul_b = $signed({1'b0, il_q});
				state_d = btcl_pkg::ST_SC2;
			end
			btcl_pkg::ST_SC2: begin
				mul_a = 33'(nx_q);
				mul_b = $signed({1'b0, ol_q});
				state_d = btcl_pkg::ST_SC3;
			end
			btcl_pkg::ST_SC3: begin
				mul_a = 33'(ny_q);
				mul_b = $signed({1'b0, ol_q});
				state_d = btcl_pkg::ST_SC4;
			end
			btcl_pkg::ST_SC4: state_d = btcl_pkg::ST_FIN;
			btcl_pkg::ST_FIN: begin
				if (fin_go) state_d = btcl_pkg::ST_IDLE;
			end
			default: state_d = btcl_pkg::ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			btcl_pkg::ST_IDLE: begin
				if (q_valid) begin
					ix_q <= q_item.ix;
					iy_q <= q_item.iy;
					ox_q <= q_item.ox;
					oy_q <= q_item.oy;
					nix_q <= q_item.ix;
					niy_q <= q_item.iy;
					nox_q <= q_item.ox;
					noy_q <= q_item.oy;
					locked_q <= 1'b0;
					dev_q <= '0;
				end
			end
			btcl_pkg::ST_ISQ1, btcl_pkg::ST_OSQ1, btcl_pkg::ST_DOT1, btcl_pkg::ST_DL1: begin
				acc_q <= prod_q;
			end
			btcl_pkg::ST_IRT: begin
				if (sq_done) il_q <= sq_root;
			end
			btcl_pkg::ST_ORT: begin
				if (sq_done) ol_q <= sq_root;
			end
			btcl_pkg::ST_DVW: begin
				if (dv_done) begin
					case (dsel_q)
						3'd0: uix_q <= dv_quo;
						3'd1: uiy_q <= dv_quo;
						3'd2: uox_q <= dv_quo;
						3'd3: uoy_q <= dv_quo;
						3'd4: nx_q <= dv_quo;
						default: ny_q <= dv_quo;
					endcase
				end
			end
			btcl_pkg::ST_DOT2: c_q <= c_w;
			btcl_pkg::ST_CSW: begin
				if (sq_done) s_q <= sq_root;
			end
			btcl_pkg::ST_CRI: begin
				// quarter turn first when the angle is obtuse
				if (c_q < 32'sd0) begin
					cx_q <= $signed({2'b00, s_q});
					cy_q <= -34'(c_q);
					cz_q <= btcl_pkg::HALF_PI_Q30;
				end else begin
					cx_q <= 34'(c_q);
					cy_q <= $signed({2'b00, s_q});
					cz_q <= '0;
				end
			end
			btcl_pkg::ST_CRS: begin
				if (cy_q > 34'sd0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + atan_w;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - atan_w;
				end
			end
			btcl_pkg::ST_DEG1: begin
				dev_q <= btcl_pkg::DEG180_Q16 - deg_c;
				dx_q <= 33'(uox_q) - 33'(uix_q);
				dy_q <= 33'(uoy_q) - 33'(uiy_q);
			end
			btcl_pkg::ST_DLW: begin
				// short difference falls back to the outgoing direction
				if (sq_done && sq_root <= {21'd0, degenerate_limit}) begin
					nx_q <= uox_q;
					ny_q <= uoy_q;
				end
			end
			btcl_pkg::ST_SC1: nix_q <= scale_w;
			btcl_pkg::ST_SC2: niy_q <= scale_w;
			btcl_pkg::ST_SC3: nox_q <= scale_w;
			btcl_pkg::ST_SC4: begin
				noy_q <= scale_w;
				locked_q <= 1'b1;
			end
			default: ;
		endcase
		if (fin_go) begin
			o_nix_q <= nix_q;
			o_niy_q <= niy_q;
			o_nox_q <= nox_q;
			o_noy_q <= noy_q;
			o_locked_q <= locked_q;
			o_dev_q <= dev_q;
			o_pairs_q <= pairs_n;
			o_maxdev_q <= maxdev_n;
		end
	end

	// sequencer state, counters, statistics and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btcl_pkg::ST_IDLE;
			dsel_q <= '0;
			step_q <= '0;
			pairs_q <= '0;
			maxdev_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == btcl_pkg::ST_IDLE && q_valid) begin
				dsel_q <= '0;
				if (q_item.clear) begin
					pairs_q <= '0;
					maxdev_q <= '0;
				end
			end
			if (state_q == btcl_pkg::ST_DVW && dv_done) dsel_q <= dsel_q + 1'b1;
			if (state_q == btcl_pkg::ST_CRI) step_q <= '0;
			else if (state_q == btcl_pkg::ST_CRS) step_q <= step_q + 1'b1;
			if (fin_go) begin
				pairs_q <= pairs_n;
				maxdev_q <= maxdev_n;
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign new_in_x = o_nix_q;
	assign new_in_y = o_niy_q;
	assign new_out_x = o_nox_q;
	assign new_out_y = o_noy_q;
	assign locked = o_locked_q;
	assign deviation = o_dev_q;
	assign running_pairs = o_pairs_q;
	assign running_max_dev = o_maxdev_q;

`ifndef SYNTH
	a_unlocked_zero_dev: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !o_locked_q |-> o_dev_q == '0)
		else $error("unlocked vertex with nonzero deviation");
	a_dev_range: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> o_dev_q <= btcl_pkg::DEG180_Q16)
		else $error("deviation above straight angle");
	a_stats_cover_locked: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && o_locked_q |-> o_maxdev_q >= o_dev_q && o_pairs_q != '0)
		else $error("running statistics miss a locked vertex");
	a_sqrt_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !sq_busy)
		else $error("square root started while busy");
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dv_start |-> !dv_busy)
		else $error("divider started while busy");
`endif

endmodule

### hdl/bezier_tangent_collinear_lock.sv
// the back end handles one vertex at a time, using the square root four times and
// the divider up to six times; a 2-deep queue takes new vertices meanwhile
// reset: arst_n clears the configuration and sequencer state, the running count and
// maximum, the queue pointers and the valid flags
module bezier_tangent_collinear_lock #(
	parameter int unsigned CORDIC_STEPS = btcl_pkg::CORDIC_STEPS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic signed [31:0] in_tan_x,
	input logic signed [31:0] in_tan_y,
	input logic signed [31:0] out_tan_x,
	input logic signed [31:0] out_tan_y,
	input logic bypass,
	input logic clear_stats,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] new_in_x,
	output logic signed [31:0] new_in_y,
	output logic signed [31:0] new_out_x,
	output logic signed [31:0] new_out_y,
	output logic locked,
	output logic [23:0] deviation,
	output logic [15:0] running_pairs,
	output logic [23:0] running_max_dev
);

	logic [15:0] min_length_q;
	logic [10:0] degen_limit_q;
	btcl_pkg::item_t q_item;
	logic q_valid, q_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= '0;
			degen_limit_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				btcl_pkg::REG_MIN_LENGTH: min_length_q <= cfg_data;
				btcl_pkg::REG_DEGEN_LIMIT: degen_limit_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	btcl_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.in_tan_x(in_tan_x), .in_tan_y(in_tan_y),
		.out_tan_x(out_tan_x), .out_tan_y(out_tan_y),
		.bypass(bypass), .clear_stats(clear_stats),
		.q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
	);

	btcl_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
		.min_length(min_length_q), .degenerate_limit(degen_limit_q),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_in_x(new_in_x), .new_in_y(new_in_y),
		.new_out_x(new_out_x), .new_out_y(new_out_y),
		.locked(locked), .deviation(deviation),
		.running_pairs(running_pairs), .running_max_dev(running_max_dev)
	);

endmodule
